/* design/two_level_run_queue_scheduler_unit_defines.svh */
// Assertion macros shared by the scheduler RTL.
`ifndef TWO_LEVEL_RUN_QUEUE_SCHEDULER_UNIT_DEFINES_SVH
`define TWO_LEVEL_RUN_QUEUE_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TLRQS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TLRQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

/* design/tlrqs_pkg.sv */
// Package with the types and fixed constants of the two-level run queue scheduler.
`default_nettype none

package tlrqs_pkg;

    // Width of a task identifier.
    localparam int ID_W = 16;

    // Widths of the configuration registers.
    localparam int WORKER_W = 7;
    localparam int FAIR_W   = 8;
    localparam int CFG_W    = 8;

    // Register reset values.
    localparam logic [WORKER_W-1:0] WORKER_RESET   = 7'd1;
    localparam logic [FAIR_W-1:0]   FAIRNESS_RESET = 8'd61;

    // Configuration register indexes.
    localparam logic CFG_WORKER_COUNT    = 1'b0;
    localparam logic CFG_FAIRNESS_PERIOD = 1'b1;

    // Operation codes of an input word.
    localparam logic OP_ENQUEUE  = 1'b0;
    localparam logic OP_SCHEDULE = 1'b1;

    // One result word.
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] picked_task;
        logic            spilled;
        logic            dropped;
    } result_t;

endpackage

`default_nettype wire

/* design/tlrqs_in_if.sv */
// Input channel interface: operation and task id with a valid/ready handshake.
`default_nettype none

interface tlrqs_in_if import tlrqs_pkg::*;;
    logic            valid;
    logic            ready;
    logic            op;
    logic [ID_W-1:0] task_id;

    modport source (output valid, output op, output task_id, input ready);
    modport sink   (input valid, input op, input task_id, output ready);
endinterface

`default_nettype wire

/* design/tlrqs_out_if.sv */
// Output channel interface: one scheduling result with a valid/ready handshake.
`default_nettype none

interface tlrqs_out_if import tlrqs_pkg::*;;
    logic            valid;
    logic            ready;
    logic            found;
    logic [ID_W-1:0] picked_task;
    logic            spilled;
    logic            dropped;

    modport source (output valid, output found, output picked_task, output spilled,
                     output dropped, input ready);
    modport sink   (input valid, input found, input picked_task, input spilled,
                     input dropped, output ready);
endinterface

`default_nettype wire

/* design/tlrqs_divider.sv */
// Restoring divider, one quotient bit per cycle, for the batch size.
`default_nettype none

module tlrqs_divider import tlrqs_pkg::*; #(
    parameter int DIVIDEND_W = 11
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [WORKER_W-1:0]   divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [WORKER_W-1:0]   rem_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [WORKER_W-1:0]   div_reg;

    logic [WORKER_W:0]     shifted;
    logic                  ge;
    logic [WORKER_W:0]     rem_diff;
    logic [WORKER_W-1:0]   rem_next;
    logic [DIVIDEND_W-1:0] quot_next;

    // The remainder stays below the divisor, so it fits the divisor width.
    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIVIDEND_W-1]};
        ge        = (shifted >= {1'b0, div_reg});
        rem_diff  = ge ? (shifted - {1'b0, div_reg}) : shifted;
        rem_next  = rem_diff[WORKER_W-1:0];
        quot_next = {quot_reg[DIVIDEND_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= dividend;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* design/two_level_run_queue_scheduler_unit.sv */
// Top level of the two-level run queue scheduler: sequencer, queues and result register.
// Usage: words arrive on sched_in (op, task_id) and one result word per input word
// leaves on sched_out (found, picked_task, spilled, dropped), both valid/ready channels.
// An input word is taken only while the sequencer is idle; one word is worked on at a time.
// An enqueue word goes from accept straight to S_RESP. A schedule word served
// from the local ring passes S_RGET and then S_RESP; one that finds nothing goes to S_RESP.
// A schedule word served from the overflow FIFO runs the bit-serial divider
// (one quotient bit per bit of the overflow count, 11 bits at the default depth) and then
// moves the batch one task at a time through S_OPOP and S_OWR before S_RESP.
// The divider and the single read port of each queue memory set these steps.
// The result sits in an output register, so the next input word is accepted while a
// finished result still waits; when the receiver stalls, a second result waits in the
// sequencer and no further word is taken until the register frees up.
// cfg_we writes worker_count (index 0) or fairness_period (index 1).
// Reset empties both queues, clears the pick phase and loads the register defaults;
// the queue memories themselves are not cleared, and no entry is used before it is written.
`default_nettype none

`include "two_level_run_queue_scheduler_unit_defines.svh"

module two_level_run_queue_scheduler_unit import tlrqs_pkg::*; #(
    parameter int LOCAL_DEPTH    = 256,
    parameter int OVERFLOW_DEPTH = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    tlrqs_in_if.sink              sched_in,
    tlrqs_out_if.source           sched_out,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    // Pointer and count widths follow from the queue depths.
    localparam int LPW  = $clog2(LOCAL_DEPTH);
    localparam int OPW  = $clog2(OVERFLOW_DEPTH);
    localparam int CW   = $clog2(OVERFLOW_DEPTH + 1);
    localparam int CMPW = (CW > LPW) ? CW : LPW;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_OPOP = 6'b000100,
        S_OWR  = 6'b001000,
        S_RGET = 6'b010000,
        S_RESP = 6'b100000
    } sched_state_t;

    sched_state_t          state_reg, state_next;
    logic [LPW-1:0]        lhead_reg, lhead_next;
    logic [LPW-1:0]        ltail_reg, ltail_next;
    logic [OPW-1:0]        ohead_reg, ohead_next;
    logic [OPW-1:0]        otail_reg, otail_next;
    logic [CW-1:0]         ocount_reg, ocount_next;
    logic [FAIR_W-1:0]     phase_reg, phase_next;
    logic [LPW-1:0]        batch_reg, batch_next;
    logic                  first_reg, first_next;
    result_t               res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_res_reg;
    logic [WORKER_W-1:0]   worker_reg;
    logic [FAIR_W-1:0]     fairness_reg;

    // Queue memories; read data is registered and always points at the head.
    logic [ID_W-1:0]       ring_mem [LOCAL_DEPTH];
    logic [ID_W-1:0]       ovf_mem  [OVERFLOW_DEPTH];
    logic [ID_W-1:0]       ring_rdata_reg;
    logic [ID_W-1:0]       ovf_rdata_reg;
    logic                  ring_we;
    logic [ID_W-1:0]       ring_wdata;
    logic                  ovf_we;

    logic                  in_accept;
    logic                  out_free;
    logic [LPW:0]          used_wide;
    logic [LPW-1:0]        ring_used;
    logic [LPW-1:0]        ring_space;
    logic                  ring_full;
    logic                  ring_empty;
    logic                  ovf_full;
    logic [LPW-1:0]        lhead_inc;
    logic [LPW-1:0]        ltail_inc;
    logic [OPW-1:0]        ohead_inc;
    logic [OPW-1:0]        otail_inc;
    logic [FAIR_W-1:0]     period;
    logic [FAIR_W:0]       phase_sum;
    logic [FAIR_W-1:0]     phase_adv;
    logic [WORKER_W-1:0]   workers;
    logic                  take_ovf;
    logic                  div_start;
    logic                  div_done;
    logic [CW-1:0]         div_quot;
    logic [LPW-1:0]        batch_cap;

    assign in_accept = sched_in.valid && sched_in.ready;
    assign out_free  = !out_valid_reg || sched_out.ready;
    assign sched_in.ready = (state_reg == S_IDLE);

    // Ring occupancy modulo the ring size; the ring holds at most LOCAL_DEPTH-1 tasks.
    always_comb
    begin
        if (ltail_reg >= lhead_reg)
        begin
            used_wide = {1'b0, ltail_reg} - {1'b0, lhead_reg};
        end
        else
        begin
            used_wide = {1'b0, ltail_reg} + (LPW+1)'(LOCAL_DEPTH) - {1'b0, lhead_reg};
        end
    end

    assign ring_used  = used_wide[LPW-1:0];
    assign ring_space = LPW'(LOCAL_DEPTH - 1) - ring_used;
    assign ring_full  = (ring_used == LPW'(LOCAL_DEPTH - 1));
    assign ring_empty = (lhead_reg == ltail_reg);
    assign ovf_full   = (ocount_reg == CW'(OVERFLOW_DEPTH));

    // Pointers wrap at the queue depth, which need not be a power of two.
    assign lhead_inc = (lhead_reg == LPW'(LOCAL_DEPTH - 1)) ? '0 : lhead_reg + LPW'(1);
    assign ltail_inc = (ltail_reg == LPW'(LOCAL_DEPTH - 1)) ? '0 : ltail_reg + LPW'(1);
    assign ohead_inc = (ohead_reg == OPW'(OVERFLOW_DEPTH - 1)) ? '0 : ohead_reg + OPW'(1);
    assign otail_inc = (otail_reg == OPW'(OVERFLOW_DEPTH - 1)) ? '0 : otail_reg + OPW'(1);

    // A period or worker count of zero behaves as one.
    assign period    = (fairness_reg == '0) ? FAIR_W'(1) : fairness_reg;
    assign phase_sum = {1'b0, phase_reg} + (FAIR_W+1)'(1);
    assign phase_adv = (phase_sum >= {1'b0, period}) ? '0 : phase_sum[FAIR_W-1:0];
    assign workers   = (worker_reg == '0) ? WORKER_W'(1) : worker_reg;

    // The overflow FIFO serves the pick on a fairness turn or when the ring is empty.
    assign take_ovf  = (ocount_reg != '0) && ((phase_reg == '0) || ring_empty);
    assign div_start = in_accept && (sched_in.op == OP_SCHEDULE) && take_ovf;

    // Batch size: quotient capped by free ring space, and never below one.
    always_comb
    begin
        if (CMPW'(div_quot) > CMPW'(ring_space))
        begin
            batch_cap = ring_space;
        end
        else
        begin
            batch_cap = LPW'(div_quot);
        end
        if (batch_cap == '0)
        begin
            batch_cap = LPW'(1);
        end
    end

    tlrqs_divider #(
        .DIVIDEND_W (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ocount_reg),
        .divisor  (workers),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        lhead_next     = lhead_reg;
        ltail_next     = ltail_reg;
        ohead_next     = ohead_reg;
        otail_next     = otail_reg;
        ocount_next    = ocount_reg;
        phase_next     = phase_reg;
        batch_next     = batch_reg;
        first_next     = first_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        ring_we        = 1'b0;
        ring_wdata     = sched_in.task_id;
        ovf_we         = 1'b0;

        if (out_valid_reg && sched_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_next = '0;
                    if (sched_in.op == OP_ENQUEUE)
                    begin
                        if (!ring_full)
                        begin
                            ring_we    = 1'b1;
                            ltail_next = ltail_inc;
                        end
                        else if (!ovf_full)
                        begin
                            ovf_we           = 1'b1;
                            otail_next       = otail_inc;
                            ocount_next      = ocount_reg + CW'(1);
                            res_next.spilled = 1'b1;
                        end
                        else
                        begin
                            res_next.dropped = 1'b1;
                        end
                        state_next = S_RESP;
                    end
                    else if (take_ovf)
                    begin
                        state_next = S_DIV;
                    end
                    else if (!ring_empty)
                    begin
                        lhead_next = lhead_inc;
                        state_next = S_RGET;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    batch_next = batch_cap;
                    first_next = 1'b1;
                    state_next = S_OPOP;
                end
            end

            S_OPOP:
            begin
                ohead_next  = ohead_inc;
                ocount_next = ocount_reg - CW'(1);
                batch_next  = batch_reg - LPW'(1);
                state_next  = S_OWR;
            end

            S_OWR:
            begin
                // The oldest task of the batch is the pick; the rest refill the ring.
                if (first_reg)
                begin
                    res_next.picked_task = ovf_rdata_reg;
                    first_next           = 1'b0;
                end
                else
                begin
                    ring_we    = 1'b1;
                    ring_wdata = ovf_rdata_reg;
                    ltail_next = ltail_inc;
                end
                if ((batch_reg != '0) && (ocount_reg != '0))
                begin
                    state_next = S_OPOP;
                end
                else
                begin
                    res_next.found = 1'b1;
                    phase_next     = phase_adv;
                    state_next     = S_RESP;
                end
            end

            S_RGET:
            begin
                res_next.picked_task = ring_rdata_reg;
                res_next.found       = 1'b1;
                phase_next           = phase_adv;
                state_next           = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lhead_reg     <= '0;
            ltail_reg     <= '0;
            ohead_reg     <= '0;
            otail_reg     <= '0;
            ocount_reg    <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            worker_reg    <= WORKER_RESET;
            fairness_reg  <= FAIRNESS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            lhead_reg     <= lhead_next;
            ltail_reg     <= ltail_next;
            ohead_reg     <= ohead_next;
            otail_reg     <= otail_next;
            ocount_reg    <= ocount_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WORKER_COUNT:    worker_reg   <= cfg_wdata[WORKER_W-1:0];
                    CFG_FAIRNESS_PERIOD: fairness_reg <= cfg_wdata[FAIR_W-1:0];
                    default:             fairness_reg <= fairness_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
        first_reg <= first_next;
        res_reg   <= res_next;
        if ((state_reg == S_RESP) && out_free)
        begin
            out_res_reg <= res_reg;
        end
    end

    // Both queue writes land at the tail; both reads follow the head.
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ltail_reg] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[lhead_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ovf_we)
        begin
            ovf_mem[otail_reg] <= sched_in.task_id;
        end
        ovf_rdata_reg <= ovf_mem[ohead_reg];
    end

    assign sched_out.valid       = out_valid_reg;
    assign sched_out.found       = out_res_reg.found;
    assign sched_out.picked_task = out_res_reg.picked_task;
    assign sched_out.spilled     = out_res_reg.spilled;
    assign sched_out.dropped     = out_res_reg.dropped;

    // The overflow count never exceeds the FIFO depth.
    `TLRQS_ASSERT_IMPL(a_ovf_count_bound, 1'b1, ocount_reg <= CW'(OVERFLOW_DEPTH))
    // A pop from the overflow FIFO never happens while it is empty.
    `TLRQS_ASSERT_IMPL(a_no_empty_pop, state_reg == S_OPOP, ocount_reg != '0)
    // A new result appears only after the sequencer handed it over.
    `TLRQS_ASSERT_IMPL(a_result_source, $rose(out_valid_reg), $past(state_reg == S_RESP))

endmodule

`default_nettype wire

/* test/two_level_run_queue_scheduler_unit_tb.sv */
// Self-checking testbench for the two-level run queue scheduler unit.
`timescale 1ns / 1ps

module two_level_run_queue_scheduler_unit_tb;
    import tlrqs_pkg::*;

    // The block is built at its default depths, so the shadow queues below
    // use the same sizes.
    localparam int LOCAL_DEPTH    = 256;
    localparam int OVERFLOW_DEPTH = 1024;

    // The slowest legal word is an overflow pick that moves a full ring's worth
    // of tasks. Add the longest receiver stall and sender gap, then take that
    // several times over.
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int DRAIN_CYCLES      = 100;
    localparam int RANDOM_PHASES     = 4;
    localparam int PHASE_WORDS       = 20;
    localparam int FLOOD_DRAIN_WORDS = 40;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;

    tlrqs_in_if  sched_in_bus ();
    tlrqs_out_if sched_out_bus ();

    two_level_run_queue_scheduler_unit #(
        .LOCAL_DEPTH    (LOCAL_DEPTH),
        .OVERFLOW_DEPTH (OVERFLOW_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sched_in  (sched_in_bus),
        .sched_out (sched_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the scheduler state. It is advanced once per accepted
    // input word, at the clock edge where the word is taken.
    logic [ID_W-1:0]     ring_mem [LOCAL_DEPTH];
    int                  ring_head;
    int                  ring_tail;
    logic [ID_W-1:0]     spill_mem [OVERFLOW_DEPTH];
    int                  spill_head;
    int                  spill_tail;
    int                  spill_count;
    int                  pick_phase;
    logic [WORKER_W-1:0] cfg_workers;
    logic [FAIR_W-1:0]   cfg_period;

    // Results the block still owes us, oldest first.
    result_t             pending_results [$];

    int                  mismatches;
    int                  quiet_cycles;
    int                  stall_hold;
    // When set, neither side inserts gaps, so words go back to back.
    bit                  no_idle;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow model of the two queues.
    // ------------------------------------------------------------------

    function automatic int ring_used();
        return (ring_tail + LOCAL_DEPTH - ring_head) % LOCAL_DEPTH;
    endfunction

    function automatic int tasks_waiting();
        return ring_used() + spill_count;
    endfunction

    function automatic void ring_push(input logic [ID_W-1:0] id);
        ring_mem[ring_tail] = id;
        ring_tail = (ring_tail + 1) % LOCAL_DEPTH;
    endfunction

    function automatic logic [ID_W-1:0] spill_pop();
        logic [ID_W-1:0] id;
        id = spill_mem[spill_head];
        spill_head = (spill_head + 1) % OVERFLOW_DEPTH;
        spill_count--;
        return id;
    endfunction

    // Takes the oldest overflow task and moves the rest of its batch into the
    // ring. The batch is the overflow count over the worker count, capped by
    // the free ring space, and never less than one.
    function automatic bit take_from_overflow(output logic [ID_W-1:0] id);
        int workers;
        int batch;
        int space;
        id = '0;
        if (spill_count == 0)
            return 1'b0;
        workers = (cfg_workers == 0) ? 1 : int'(cfg_workers);
        batch = spill_count / workers;
        space = (LOCAL_DEPTH - 1) - ring_used();
        if (batch > space)
            batch = space;
        if (batch == 0)
            batch = 1;
        id = spill_pop();
        batch--;
        while (batch > 0 && spill_count > 0)
        begin
            ring_push(spill_pop());
            batch--;
        end
        return 1'b1;
    endfunction

    // Works out the result of one input word and updates the shadow state.
    function automatic result_t predict_result(input logic op, input logic [ID_W-1:0] id);
        result_t         res;
        bit              got;
        int              period;
        logic [ID_W-1:0] picked;
        res = '0;
        picked = '0;
        if (op == OP_ENQUEUE)
        begin
            if (ring_used() != LOCAL_DEPTH - 1)
                ring_push(id);
            else if (spill_count < OVERFLOW_DEPTH)
            begin
                spill_mem[spill_tail] = id;
                spill_tail = (spill_tail + 1) % OVERFLOW_DEPTH;
                spill_count++;
                res.spilled = 1'b1;
            end
            else
                res.dropped = 1'b1;
        end
        else
        begin
            period = (cfg_period == 0) ? 1 : int'(cfg_period);
            got = 1'b0;
            // Fairness turn: the overflow queue goes first.
            if (pick_phase == 0 && spill_count > 0)
                got = take_from_overflow(picked);
            if (!got && ring_head != ring_tail)
            begin
                picked = ring_mem[ring_head];
                ring_head = (ring_head + 1) % LOCAL_DEPTH;
                got = 1'b1;
            end
            if (!got)
                got = take_from_overflow(picked);
            if (got)
            begin
                res.found = 1'b1;
                res.picked_task = picked;
                pick_phase = (pick_phase + 1 >= period) ? 0 : pick_phase + 1;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    function automatic logic [ID_W-1:0] random_id();
        return ID_W'($urandom);
    endfunction

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one word at the falling edge and holds it until the rising edge
    // where ready is high. The expected result is computed at that edge. The
    // valid line is only lowered when a gap follows, so back-to-back words
    // never see valid drop and rise in the same time step.
    task automatic send_word(input logic op, input logic [ID_W-1:0] id);
        int gap;
        sched_in_bus.valid   <= 1'b1;
        sched_in_bus.op      <= op;
        sched_in_bus.task_id <= id;
        do
            @(posedge clk);
        while (sched_in_bus.ready !== 1'b1);
        pending_results.push_back(predict_result(op, id));
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            sched_in_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stops sending and waits until every owed result has come back, so the
    // block is idle and its registers may be rewritten.
    task automatic settle_idle();
        sched_in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        if (index == CFG_WORKER_COUNT)
            cfg_workers = value[WORKER_W-1:0];
        else
            cfg_period = value[FAIR_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] workers, input logic [CFG_W-1:0] period);
        settle_idle();
        write_reg(CFG_WORKER_COUNT, workers);
        write_reg(CFG_FAIRNESS_PERIOD, period);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Requests right after reset find nothing runnable.
    task automatic test_empty_request();
        send_word(OP_SCHEDULE, 16'hFFFF);
        send_word(OP_SCHEDULE, 16'h0000);
    endtask

    // Tasks come back from the local ring in arrival order, extreme ids
    // included, and a request past the last one finds nothing.
    task automatic test_local_fifo_order();
        send_word(OP_ENQUEUE, 16'h0000);
        send_word(OP_ENQUEUE, 16'hFFFF);
        send_word(OP_ENQUEUE, 16'hA5A5);
        send_word(OP_ENQUEUE, 16'h5A5A);
        repeat (5) send_word(OP_SCHEDULE, random_id());
    endtask

    // A zero worker count and a zero fairness period both act as one.
    task automatic test_zero_config();
        configure(8'd0, 8'd0);
        send_word(OP_ENQUEUE, random_id());
        send_word(OP_ENQUEUE, random_id());
        repeat (3) send_word(OP_SCHEDULE, random_id());
    endtask

    // Register extremes: all bits set on both writes, then a worker count of
    // 64 with the shortest period.
    task automatic test_register_extremes();
        configure(8'hFF, 8'hFF);
        send_word(OP_ENQUEUE, random_id());
        send_word(OP_SCHEDULE, random_id());
        configure(8'd64, 8'd1);
        send_word(OP_ENQUEUE, random_id());
        send_word(OP_SCHEDULE, random_id());
    endtask

    // Fills the ring, then the overflow queue, then drops a few tasks. It then
    // sends a run of mostly requests, which exercises fairness turns, batch
    // moves capped by ring space and batches of one.
    task automatic test_overflow_flood(input logic [CFG_W-1:0] workers,
                                       input logic [CFG_W-1:0] period);
        int fill;
        configure(workers, period);
        fill = (LOCAL_DEPTH - 1 + OVERFLOW_DEPTH) - tasks_waiting() + $urandom_range(3, 10);
        repeat (fill) send_word(OP_ENQUEUE, random_id());
        repeat (FLOOD_DRAIN_WORDS)
        begin
            if ($urandom_range(0, 99) < 85)
                send_word(OP_SCHEDULE, random_id());
            else
                send_word(OP_ENQUEUE, random_id());
        end
        send_word(OP_SCHEDULE, random_id());
    endtask

    // Random traffic in phases. Each phase picks new register values and a
    // mix of enqueues and requests, so the queue levels drift up and down
    // across phases. One phase runs with no idling on either side.
    task automatic test_random_traffic();
        int                enq_pct;
        logic [CFG_W-1:0]  workers;
        logic [CFG_W-1:0]  period;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       workers = CFG_W'($urandom_range(1, 4));
                1:       workers = 8'd64;
                2:       workers = $urandom_range(0, 1) ? 8'd0 : 8'd127;
                default: workers = CFG_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       period = CFG_W'($urandom_range(1, 4));
                1:       period = 8'd255;
                2:       period = 8'd61;
                default: period = CFG_W'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 25;
            endcase
            configure(workers, period);
            no_idle = (phase == 2);
            repeat (PHASE_WORDS)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                    send_word(OP_ENQUEUE, random_id());
                else
                    send_word(OP_SCHEDULE, random_id());
            end
            no_idle = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_WORKER_COUNT;
        cfg_wdata            = '0;
        sched_in_bus.valid   = 1'b0;
        sched_in_bus.op      = OP_ENQUEUE;
        sched_in_bus.task_id = '0;
        mismatches           = 0;
        no_idle              = 1'b0;
        ring_head            = 0;
        ring_tail            = 0;
        spill_head           = 0;
        spill_tail           = 0;
        spill_count          = 0;
        pick_phase           = 0;
        cfg_workers          = WORKER_RESET;
        cfg_period           = FAIRNESS_RESET;

        // Reset is held low and released on a falling edge.
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_request();
        test_local_fifo_order();
        test_overflow_flood(8'd64, 8'd2);
        test_zero_config();
        test_register_extremes();
        test_random_traffic();

        // Let every owed result arrive, then watch a while longer for any
        // result word the block should not have produced.
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("two_level_run_queue_scheduler_unit test passed");
        else
            $display("two_level_run_queue_scheduler_unit test failed");
        $finish;
    end

    // Receiver side: ready changes on the falling edge. Most cycles accept,
    // some stall briefly and a few stall for a long stretch.
    initial
    begin
        sched_out_bus.ready = 1'b0;
        stall_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                stall_hold--;
                sched_out_bus.ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 99) < 20)
            begin
                stall_hold = ($urandom_range(0, 99) < 90) ? int'($urandom_range(0, 2))
                                                          : int'($urandom_range(20, 60));
                sched_out_bus.ready <= 1'b0;
            end
            else
                sched_out_bus.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [ID_W-1:0] want,
                               input logic [ID_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every result word taken at a rising edge is compared, field by field,
    // with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && sched_out_bus.valid === 1'b1 && sched_out_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %b %h %b %b",
                         $time, sched_out_bus.found, sched_out_bus.picked_task,
                         sched_out_bus.spilled, sched_out_bus.dropped);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("found", ID_W'(want.found), ID_W'(sched_out_bus.found));
                check_field("picked_task", want.picked_task, sched_out_bus.picked_task);
                check_field("spilled", ID_W'(want.spilled), ID_W'(sched_out_bus.spilled));
                check_field("dropped", ID_W'(want.dropped), ID_W'(sched_out_bus.dropped));
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((sched_in_bus.valid === 1'b1 && sched_in_bus.ready === 1'b1) ||
                 (sched_out_bus.valid === 1'b1 && sched_out_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("two_level_run_queue_scheduler_unit test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
